// File: sv/gdn_pkg.sv
`timescale 1ns / 1ps

package gdn_pkg;

  // Fixed-point full scale: 32767 stands for 1.0.
  localparam logic [14:0] FULL_SCALE = 15'h7fff;

  // Configuration register indexes.
  localparam logic [1:0] REG_LEFT_DZ   = 2'd0;
  localparam logic [1:0] REG_RIGHT_DZ  = 2'd1;
  localparam logic [1:0] REG_TRIG_THR  = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [14:0] LEFT_DZ_RST  = 15'd7849;
  localparam logic [14:0] RIGHT_DZ_RST = 15'd8689;
  localparam logic [14:0] TRIG_THR_RST = 15'd30;

  // Pipeline geometry.
  localparam int SQRT_STAGES = 16;
  localparam int DIV_STAGES  = 15;
  localparam int STICK_LAT   = 2 + SQRT_STAGES + 3 + DIV_STAGES;
  localparam int TRIG_DLY    = STICK_LAT - 2 - DIV_STAGES;

endpackage

// File: sv/gdn_isqrt.sv
`timescale 1ns / 1ps

module gdn_isqrt #(
  parameter int PW = 32
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [31:0]   rad_i,
  input  logic [PW-1:0] pay_i,
  output logic [15:0]   root_o,
  output logic [PW-1:0] pay_o
);
  import gdn_pkg::*;

  logic [17:0]   rem_q  [SQRT_STAGES];
  logic [15:0]   root_q [SQRT_STAGES];
  logic [31:0]   rad_q  [SQRT_STAGES];
  logic [PW-1:0] pay_q  [SQRT_STAGES];

  // One root bit per stage: bring down two radicand bits and try {root, 01}.
  for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stage
    logic [17:0]   rem_p;
    logic [15:0]   root_p;
    logic [31:0]   rad_p;
    logic [PW-1:0] pay_p;
    logic [19:0]   r2, trial;
    logic          ge;

    if (s == 0) begin : g_first
      assign rem_p  = '0;
      assign root_p = '0;
      assign rad_p  = rad_i;
      assign pay_p  = pay_i;
    end else begin : g_next
      assign rem_p  = rem_q[s-1];
      assign root_p = root_q[s-1];
      assign rad_p  = rad_q[s-1];
      assign pay_p  = pay_q[s-1];
    end

    assign r2    = {rem_p, rad_p[31:30]};
    assign trial = {2'b00, root_p, 2'b01};
    assign ge    = (r2 >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= ge ? 18'(r2 - trial) : r2[17:0];
        root_q[s] <= {root_p[14:0], ge};
        rad_q[s]  <= {rad_p[29:0], 2'b00};
        pay_q[s]  <= pay_p;
      end
    end
  end

  assign root_o = root_q[SQRT_STAGES-1];
  assign pay_o  = pay_q[SQRT_STAGES-1];

endmodule

// File: sv/gdn_div.sv
`timescale 1ns / 1ps

module gdn_div #(
  parameter int NW = 46,
  parameter int DW = 31,
  parameter int PW = 1
) (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic [NW-1:0]                   num_i,
  input  logic [DW-1:0]                   den_i,
  input  logic [PW-1:0]                   pay_i,
  output logic [gdn_pkg::DIV_STAGES-1:0]  quo_o,
  output logic [PW-1:0]                   pay_o
);
  import gdn_pkg::*;

  logic [NW-1:0]         rem_q [DIV_STAGES];
  logic [DW-1:0]         den_q [DIV_STAGES];
  logic [DIV_STAGES-1:0] quo_q [DIV_STAGES];
  logic [PW-1:0]         pay_q [DIV_STAGES];

  // Restoring division, most significant quotient bit first.
  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    localparam int K = DIV_STAGES - 1 - s;
    logic [NW-1:0]         rem_p, dsh;
    logic [DW-1:0]         den_p;
    logic [DIV_STAGES-1:0] quo_p;
    logic [PW-1:0]         pay_p;
    logic                  ge;

    if (s == 0) begin : g_first
      assign rem_p = num_i;
      assign den_p = den_i;
      assign quo_p = '0;
      assign pay_p = pay_i;
    end else begin : g_next
      assign rem_p = rem_q[s-1];
      assign den_p = den_q[s-1];
      assign quo_p = quo_q[s-1];
      assign pay_p = pay_q[s-1];
    end

    assign dsh = NW'(den_p) << K;
    assign ge  = (rem_p >= dsh);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= ge ? (rem_p - dsh) : rem_p;
        den_q[s] <= den_p;
        quo_q[s] <= quo_p | (DIV_STAGES'(ge) << K);
        pay_q[s] <= pay_p;
      end
    end
  end

  assign quo_o = quo_q[DIV_STAGES-1];
  assign pay_o = pay_q[DIV_STAGES-1];

endmodule

// File: sv/gdn_stick.sv
`timescale 1ns / 1ps

module gdn_stick (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [15:0] x_i,
  input  logic signed [15:0] y_i,
  input  logic [14:0]        dz_i,
  output logic signed [15:0] out_x_o,
  output logic signed [15:0] out_y_o
);
  import gdn_pkg::*;

  // Squares of the axes and their sum.
  logic [31:0]        xx_q, yy_q, sum_q;
  logic signed [15:0] x1_q, y1_q, x2_q, y2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xx_q  <= 32'(x_i * x_i);
      yy_q  <= 32'(y_i * y_i);
      x1_q  <= x_i;
      y1_q  <= y_i;
      sum_q <= xx_q + yy_q;
      x2_q  <= x1_q;
      y2_q  <= y1_q;
    end
  end

  // Magnitude.
  logic [15:0] mag;
  logic [31:0] xy_s;

  gdn_isqrt #(.PW(32)) u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .rad_i  (sum_q),
    .pay_i  ({x2_q, y2_q}),
    .root_o (mag),
    .pay_o  (xy_s)
  );

  // Dead zone test, clipped excess, and absolute axes.
  logic signed [15:0] xs, ys;
  logic [16:0]        nx17, ny17;
  logic [14:0]        mclip;
  logic               live;

  assign xs    = xy_s[31:16];
  assign ys    = xy_s[15:0];
  assign nx17  = 17'd0 - 17'({xs[15], xs});
  assign ny17  = 17'd0 - 17'({ys[15], ys});
  assign mclip = (mag > 16'(FULL_SCALE)) ? FULL_SCALE : mag[14:0];
  assign live  = (mag > 16'(dz_i)) && (dz_i != FULL_SCALE);

  logic [14:0] mc_q, den_q;
  logic [15:0] m3_q, ax_q, ay_q;
  logic        live3_q, sx3_q, sy3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mc_q    <= mclip - dz_i;
      den_q   <= FULL_SCALE - dz_i;
      m3_q    <= mag;
      ax_q    <= xs[15] ? nx17[15:0] : xs;
      ay_q    <= ys[15] ? ny17[15:0] : ys;
      live3_q <= live;
      sx3_q   <= xs[15];
      sy3_q   <= ys[15];
    end
  end

  // Products: excess times each axis, and the common divisor.
  logic [30:0] mx_q, my_q, dv4_q;
  logic        live4_q, sx4_q, sy4_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mx_q    <= 31'(mc_q * ax_q);
      my_q    <= 31'(mc_q * ay_q);
      dv4_q   <= 31'(den_q * m3_q);
      live4_q <= live3_q;
      sx4_q   <= sx3_q;
      sy4_q   <= sy3_q;
    end
  end

  // Scale the numerators by full scale with a shift and a subtract.
  logic [45:0] nx_q, ny_q;
  logic [30:0] dv5_q;
  logic        live5_q, sx5_q, sy5_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nx_q    <= {mx_q, 15'd0} - 46'(mx_q);
      ny_q    <= {my_q, 15'd0} - 46'(my_q);
      dv5_q   <= dv4_q;
      live5_q <= live4_q;
      sx5_q   <= sx4_q;
      sy5_q   <= sy4_q;
    end
  end

  // Two dividers share the divisor.
  logic [DIV_STAGES-1:0] qx, qy;
  logic [1:0]            px;
  logic                  py;

  gdn_div #(.NW(46), .DW(31), .PW(2)) u_div_x (
    .clk_i (clk_i),
    .en_i  (en_i),
    .num_i (nx_q),
    .den_i (dv5_q),
    .pay_i ({live5_q, sx5_q}),
    .quo_o (qx),
    .pay_o (px)
  );

  gdn_div #(.NW(46), .DW(31), .PW(1)) u_div_y (
    .clk_i (clk_i),
    .en_i  (en_i),
    .num_i (ny_q),
    .den_i (dv5_q),
    .pay_i (sy5_q),
    .quo_o (qy),
    .pay_o (py)
  );

  // Restore the sign, or force zero inside the dead zone.
  always_comb begin
    out_x_o = '0;
    out_y_o = '0;
    if (px[1]) begin
      out_x_o = px[0] ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
      out_y_o = py    ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
    end
  end

endmodule

// File: sv/gdn_trigger.sv
`timescale 1ns / 1ps

module gdn_trigger (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [14:0] t_i,
  input  logic [14:0] thr_i,
  output logic [14:0] out_o
);
  import gdn_pkg::*;

  // Delay line so the trigger result lines up with the stick lanes.
  logic [14:0] dly_q [TRIG_DLY];

  for (genvar s = 0; s < TRIG_DLY; s++) begin : g_dly
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dly_q[s] <= (s == 0) ? t_i : dly_q[(s == 0) ? 0 : s-1];
      end
    end
  end

  // Threshold test, excess and divisor.
  logic [14:0] t_d;
  logic [14:0] diff_q, den_q, den2_q;
  logic        live_q, live2_q;
  logic [29:0] num_q;

  assign t_d = dly_q[TRIG_DLY-1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      live_q  <= (t_d > thr_i);
      diff_q  <= t_d - thr_i;
      den_q   <= FULL_SCALE - thr_i;
      num_q   <= {diff_q, 15'd0} - 30'(diff_q);
      den2_q  <= den_q;
      live2_q <= live_q;
    end
  end

  logic [DIV_STAGES-1:0] q;
  logic                  live_o;

  gdn_div #(.NW(30), .DW(15), .PW(1)) u_div (
    .clk_i (clk_i),
    .en_i  (en_i),
    .num_i (num_q),
    .den_i (den2_q),
    .pay_i (live2_q),
    .quo_o (q),
    .pay_o (live_o)
  );

  assign out_o = live_o ? q : '0;

endmodule

// File: sv/gamepad_deadzone_normalizer.sv
`timescale 1ns / 1ps
// Gamepad dead zone normaliser.
// One request on the input channel carries a whole sample: both stick axis
// pairs and both triggers. One request on the output channel carries the
// normalised sample, with 32767 standing for full deflection.
// Channels use valid/ready; a request moves when both are high.
// A request accepted on the input channel passes through 36 pipeline stages
// (two for the squares, sixteen for the square root, three for the excess,
// the products and the scaling, fifteen for the restoring dividers) and
// then the output register, which raises out_valid_o.
// One sample enters per cycle unless the receiver stalls; two stick and two
// trigger lanes run side by side; the output register merges their results.
// When the receiver stalls with a result held, the whole pipeline freezes and
// in_ready_o falls; it rises again as soon as the held result is taken.
// Reset empties the pipeline and loads the configuration registers with their
// defaults. The configuration port writes one register at a time and must
// only be used while the pipeline is empty.
module gamepad_deadzone_normalizer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] left_x_i,
  input  logic signed [15:0] left_y_i,
  input  logic signed [15:0] right_x_i,
  input  logic signed [15:0] right_y_i,
  input  logic [14:0]        left_trigger_i,
  input  logic [14:0]        right_trigger_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] left_out_x_o,
  output logic signed [15:0] left_out_y_o,
  output logic signed [15:0] right_out_x_o,
  output logic signed [15:0] right_out_y_o,
  output logic [14:0]        left_trigger_out_o,
  output logic [14:0]        right_trigger_out_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [14:0]        cfg_wdata_i
);
  import gdn_pkg::*;

  // Configuration registers.
  logic [14:0] left_dz_q, right_dz_q, trig_thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_dz_q  <= LEFT_DZ_RST;
      right_dz_q <= RIGHT_DZ_RST;
      trig_thr_q <= TRIG_THR_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LEFT_DZ:  left_dz_q  <= cfg_wdata_i;
        REG_RIGHT_DZ: right_dz_q <= cfg_wdata_i;
        REG_TRIG_THR: trig_thr_q <= cfg_wdata_i;
        default:      ;
      endcase
    end
  end

  // The pipeline advances whenever the output register can take a result.
  logic adv;
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  // Valid bits following requests through the lanes.
  logic [STICK_LAT-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[STICK_LAT-2:0], in_valid_i};
    end
  end

  // Lanes.
  logic signed [15:0] lx, ly, rx, ry;
  logic [14:0]        lt, rt;

  gdn_stick u_left (
    .clk_i   (clk_i),
    .en_i    (adv),
    .x_i     (left_x_i),
    .y_i     (left_y_i),
    .dz_i    (left_dz_q),
    .out_x_o (lx),
    .out_y_o (ly)
  );

  gdn_stick u_right (
    .clk_i   (clk_i),
    .en_i    (adv),
    .x_i     (right_x_i),
    .y_i     (right_y_i),
    .dz_i    (right_dz_q),
    .out_x_o (rx),
    .out_y_o (ry)
  );

  gdn_trigger u_ltrig (
    .clk_i (clk_i),
    .en_i  (adv),
    .t_i   (left_trigger_i),
    .thr_i (trig_thr_q),
    .out_o (lt)
  );

  gdn_trigger u_rtrig (
    .clk_i (clk_i),
    .en_i  (adv),
    .t_i   (right_trigger_i),
    .thr_i (trig_thr_q),
    .out_o (rt)
  );

  // Output register merging the lane results.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (adv) begin
      out_valid_o <= vld_q[STICK_LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      left_out_x_o        <= lx;
      left_out_y_o        <= ly;
      right_out_x_o       <= rx;
      right_out_y_o       <= ry;
      left_trigger_out_o  <= lt;
      right_trigger_out_o <= rt;
    end
  end

  // An accepted request enters the first stage.
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> vld_q[0])
    else $error("accepted request did not enter the pipeline");

  // A request leaving the last stage lands in the output register.
  a_leave: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[STICK_LAT-1] && in_ready_o) |=> out_valid_o)
    else $error("result lost between pipeline and output register");

  // A stall freezes the whole pipeline.
  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> $stable(vld_q))
    else $error("pipeline moved while the output was stalled");

endmodule
